### sv/vv_pkg.sv
// Shared types, constants and helper functions for the velocity Verlet update unit.
`default_nettype none

package vv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int MAG_W     = 31;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int DIV_LAT   = NUM_W + 1;
    localparam int PIPE_LAT  = DIV_LAT + 5;
    localparam int PROD_W    = DATA_W + MAG_W;
    localparam int QHP_W     = NUM_W - DATA_W + MAG_W;
    localparam int FULL_W    = NUM_W + MAG_W;
    localparam int R1_W      = DATA_W + MAG_W;
    localparam int R1H_W     = R1_W - DATA_W + MAG_W;
    localparam int F2_W      = R1H_W + DATA_W;
    localparam int SUM_W     = 64;

    localparam logic [MAG_W-1:0] DT_RESET = MAG_W'(655);
    localparam logic [R1_W-1:0]  HOLD_CAP = R1_W'(1) << (R1_W - 1);
    localparam logic signed [SUM_W-1:0] MAX32 = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] MIN32 = -SUM_W'(64'sd2147483648);

    typedef enum logic {
        MODE_POS = 1'b0,
        MODE_VEL = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                     mode;
        logic signed [DATA_W-1:0]  position;
        logic signed [DATA_W-1:0]  velocity;
        logic signed [DATA_W-1:0]  force_req;
        logic signed [DATA_W-1:0]  acceleration;
        logic signed [DATA_W-1:0]  ang_velocity;
        logic signed [DATA_W-1:0]  ang_acceleration;
        logic signed [DATA_W-1:0]  moment;
        logic [MAG_W-1:0]          mass;
        logic [MAG_W-1:0]          inertia;
        logic                      is_last;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  new_position;
        logic signed [DATA_W-1:0]  new_velocity;
        logic signed [DATA_W-1:0]  new_acceleration;
        logic signed [DATA_W-1:0]  new_ang_velocity;
        logic signed [DATA_W-1:0]  new_ang_acceleration;
        logic                      ends_batch;
        logic                      divide_fault;
        logic                      saturated;
    } t_result;

    typedef struct packed {
        logic                      sat;
        logic signed [DATA_W-1:0]  val;
    } t_clamp;

    function automatic logic [DATA_W-1:0] mag32(logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (DATA_W'(0) - x) : x;
    endfunction

    function automatic logic signed [SUM_W-1:0] sx32(logic [DATA_W-1:0] x);
        return $signed({{(SUM_W-DATA_W){x[DATA_W-1]}}, x});
    endfunction

    function automatic logic signed [SUM_W-1:0] apply_sign(logic [SUM_W-2:0] m, logic neg);
        logic signed [SUM_W-1:0] s;
        s = $signed({1'b0, m});
        return neg ? -s : s;
    endfunction

    function automatic t_clamp clamp32(logic signed [SUM_W-1:0] x);
        t_clamp c;
        if (x > MAX32) begin
            c.sat = 1'b1;
            c.val = MAX32[DATA_W-1:0];
        end else if (x < MIN32) begin
            c.sat = 1'b1;
            c.val = MIN32[DATA_W-1:0];
        end else begin
            c.sat = 1'b0;
            c.val = x[DATA_W-1:0];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/vv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module vv_div import vv_pkg::*; (
    input  logic              i_clk,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [MAG_W-1:0]  i_den,
    output logic [NUM_W-1:0]  o_quo
);

    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W+1];
    logic [MAG_W-1:0] r_rem [NUM_W];
    logic [MAG_W-1:0] r_den [NUM_W];

    always_ff @(posedge i_clk) begin
        r_num[0] <= i_num;
        r_den[0] <= i_den;
        r_rem[0] <= '0;
        r_quo[0] <= '0;
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [MAG_W:0] n_trial;
        logic [MAG_W:0] n_diff;
        logic           n_ge;

        always_comb begin
            n_trial = {r_rem[k], r_num[k][NUM_W-1-k]};
            n_diff  = n_trial - {1'b0, r_den[k]};
            n_ge    = n_trial >= {1'b0, r_den[k]};
        end

        always_ff @(posedge i_clk) begin
            r_quo[k+1] <= {r_quo[k][NUM_W-2:0], n_ge};
        end

        if (k < NUM_W - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= n_ge ? n_diff[MAG_W-1:0] : n_trial[MAG_W-1:0];
                r_num[k+1] <= r_num[k];
                r_den[k+1] <= r_den[k];
            end
        end
    end

    assign o_quo = r_quo[NUM_W];

endmodule

`default_nettype wire

### sv/velocity_verlet_particle_update_top.sv
// Top level of the pipelined velocity Verlet half-step update unit.
//
//   Channel   Handshake                  Payload
//   input     start / busy               i_item   (t_item)
//   result    o_done strobe, one cycle   o_result (t_result)
//   config    i_cfg_valid / o_cfg_ready  i_cfg_data (time step)
//
// One item is accepted every cycle and its result appears on o_result with o_done.
// The latency is set by the 49-stage divider (an input register and 48 quotient-bit
// stages) followed by five arithmetic stages.
// Reset clears the valid bits and loads the default time step.
// Nothing stalls: busy stays low and the pipeline always advances.
`default_nettype none

module velocity_verlet_particle_update_top import vv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_done,
    output t_result           o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MAG_W-1:0]  i_cfg_data
);

    logic [MAG_W-1:0]   r_dt;
    logic [DIV_LAT-1:0] r_dv;
    t_item              r_ditem [DIV_LAT];
    logic [NUM_W-1:0]   quo_f, quo_m;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dt <= i_cfg_data;
        end
    end

    vv_div u_div_f (
        .i_clk (i_clk),
        .i_num ({mag32(i_item.force_req), FRAC_BITS'(0)}),
        .i_den (i_item.mass),
        .o_quo (quo_f)
    );

    vv_div u_div_m (
        .i_clk (i_clk),
        .i_num ({mag32(i_item.moment), FRAC_BITS'(0)}),
        .i_den (i_item.inertia),
        .o_quo (quo_m)
    );

    always_ff @(posedge i_clk) begin
        r_ditem[0] <= i_item;
        for (int j = 1; j < DIV_LAT; j++) begin
            r_ditem[j] <= r_ditem[j-1];
        end
    end

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_dv <= {r_dv[DIV_LAT-2:0], start && !busy};
            r_v1 <= r_dv[DIV_LAT-1];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Stage 1: quotients, acceleration clamps and first products.
    t_item            x1;
    logic             zm, zi;
    logic [NUM_W-1:0] qf, qm;
    t_clamp           ca, caa;

    always_comb begin
        x1  = r_ditem[DIV_LAT-1];
        zm  = (x1.mass == '0);
        zi  = (x1.inertia == '0);
        qf  = zm ? '0 : quo_f;
        qm  = zi ? '0 : quo_m;
        ca  = clamp32(apply_sign((SUM_W-1)'(qf), x1.force_req[DATA_W-1]));
        caa = clamp32(apply_sign((SUM_W-1)'(qm), x1.moment[DATA_W-1]));
    end

    t_item                    r1_item;
    logic                     r1_fault, r1_sat;
    logic signed [DATA_W-1:0] r1_na, r1_naa;
    logic [PROD_W-1:0]        r1_ql, r1_pv, r1_pa, r1_paa;
    logic [QHP_W-1:0]         r1_qh;

    always_ff @(posedge i_clk) begin
        r1_item  <= x1;
        r1_fault <= zm || (x1.mode == MODE_VEL && zi);
        r1_sat   <= (x1.mode == MODE_VEL) && (ca.sat || caa.sat);
        r1_na    <= ca.val;
        r1_naa   <= caa.val;
        r1_ql    <= PROD_W'(qf[DATA_W-1:0]) * PROD_W'(r_dt);
        r1_qh    <= QHP_W'(qf[NUM_W-1:DATA_W]) * QHP_W'(r_dt);
        r1_pv    <= PROD_W'(mag32(x1.velocity)) * PROD_W'(r_dt);
        r1_pa    <= PROD_W'(mag32(x1.acceleration)) * PROD_W'(r_dt);
        r1_paa   <= PROD_W'(mag32(x1.ang_acceleration)) * PROD_W'(r_dt);
    end

    // Stage 2: first position scaling, velocity and old-acceleration terms, new-acceleration products.
    logic [FULL_W-1:0] full1;
    logic [R1_W-1:0]   r1m;

    always_comb begin
        full1 = {r1_qh, DATA_W'(0)} + FULL_W'(r1_ql);
        r1m   = R1_W'(full1 >> FRAC_BITS);
    end

    t_item                    r2_item;
    logic                     r2_fault, r2_sat;
    logic signed [DATA_W-1:0] r2_na, r2_naa;
    logic [R1_W-1:0]          r2_r1;
    logic signed [SUM_W-1:0]  r2_t1, r2_ta, r2_taa;
    logic [PROD_W-1:0]        r2_pna, r2_pnaa;

    always_ff @(posedge i_clk) begin
        r2_item  <= r1_item;
        r2_fault <= r1_fault;
        r2_sat   <= r1_sat;
        r2_na    <= r1_na;
        r2_naa   <= r1_naa;
        r2_r1    <= r1m;
        r2_t1    <= apply_sign((SUM_W-1)'(r1_pv >> FRAC_BITS), r1_item.velocity[DATA_W-1]);
        r2_ta    <= apply_sign((SUM_W-1)'(r1_pa >> (FRAC_BITS + 1)),
                               r1_item.acceleration[DATA_W-1]);
        r2_taa   <= apply_sign((SUM_W-1)'(r1_paa >> (FRAC_BITS + 1)),
                               r1_item.ang_acceleration[DATA_W-1]);
        r2_pna   <= PROD_W'(mag32(r1_na)) * PROD_W'(r_dt);
        r2_pnaa  <= PROD_W'(mag32(r1_naa)) * PROD_W'(r_dt);
    end

    // Stage 3: second position products and velocity sums.
    t_item                    r3_item;
    logic                     r3_fault, r3_sat;
    logic signed [DATA_W-1:0] r3_na, r3_naa;
    logic signed [SUM_W-1:0]  r3_t1, r3_sv, r3_so;
    logic [PROD_W-1:0]        r3_l;
    logic [R1H_W-1:0]         r3_h;

    always_ff @(posedge i_clk) begin
        r3_item  <= r2_item;
        r3_fault <= r2_fault;
        r3_sat   <= r2_sat;
        r3_na    <= r2_na;
        r3_naa   <= r2_naa;
        r3_t1    <= r2_t1;
        r3_l     <= PROD_W'(r2_r1[DATA_W-1:0]) * PROD_W'(r_dt);
        r3_h     <= R1H_W'(r2_r1[R1_W-1:DATA_W]) * R1H_W'(r_dt);
        r3_sv    <= sx32(r2_item.velocity) + r2_ta
                  + apply_sign((SUM_W-1)'(r2_pna >> (FRAC_BITS + 1)), r2_na[DATA_W-1]);
        r3_so    <= sx32(r2_item.ang_velocity) + r2_taa
                  + apply_sign((SUM_W-1)'(r2_pnaa >> (FRAC_BITS + 1)), r2_naa[DATA_W-1]);
    end

    // Stage 4: second position scaling with the hold cap.
    logic [F2_W-1:0] full2, sh2;
    logic [R1_W-1:0] t2m;

    always_comb begin
        full2 = {r3_h, DATA_W'(0)} + F2_W'(r3_l);
        sh2   = full2 >> (FRAC_BITS + 1);
        t2m   = (sh2 > F2_W'(HOLD_CAP)) ? HOLD_CAP : sh2[R1_W-1:0];
    end

    t_item                    r4_item;
    logic                     r4_fault, r4_sat;
    logic signed [DATA_W-1:0] r4_na, r4_naa;
    logic signed [SUM_W-1:0]  r4_t1, r4_t2, r4_sv, r4_so;

    always_ff @(posedge i_clk) begin
        r4_item  <= r3_item;
        r4_fault <= r3_fault;
        r4_sat   <= r3_sat;
        r4_na    <= r3_na;
        r4_naa   <= r3_naa;
        r4_t1    <= r3_t1;
        r4_t2    <= apply_sign((SUM_W-1)'(t2m), r3_item.force_req[DATA_W-1]);
        r4_sv    <= r3_sv;
        r4_so    <= r3_so;
    end

    // Stage 5: final sums, clamps and result register.
    t_clamp  cp, cv, co;
    t_result n_res;

    always_comb begin
        cp = clamp32(sx32(r4_item.position) + r4_t1 + r4_t2);
        cv = clamp32(r4_sv);
        co = clamp32(r4_so);
        n_res.ends_batch   = r4_item.is_last;
        n_res.divide_fault = r4_fault;
        unique case (r4_item.mode)
            MODE_POS: begin
                n_res.new_position         = cp.val;
                n_res.new_velocity         = r4_item.velocity;
                n_res.new_acceleration     = r4_item.acceleration;
                n_res.new_ang_velocity     = r4_item.ang_velocity;
                n_res.new_ang_acceleration = r4_item.ang_acceleration;
                n_res.saturated            = cp.sat;
            end
            MODE_VEL: begin
                n_res.new_position         = r4_item.position;
                n_res.new_velocity         = cv.val;
                n_res.new_acceleration     = r4_na;
                n_res.new_ang_velocity     = co.val;
                n_res.new_ang_acceleration = r4_naa;
                n_res.saturated            = r4_sat || cv.sat || co.sat;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    t_result r_res;

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done   = r_v5;
    assign o_result = r_res;

endmodule

`default_nettype wire

### sv/vv_chk.sv
// Port-level checker for the velocity Verlet update unit, with its bind.
`default_nettype none

module vv_chk import vv_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input t_item             i_item,
    input logic              o_done,
    input t_result           o_result,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [MAG_W-1:0]  i_cfg_data
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_done)
        else $error("accepted item produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without accepted item");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.ends_batch == $past(i_item.is_last, PIPE_LAT))
        else $error("batch marker mismatch");

    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_item.mass, PIPE_LAT) == '0) |-> o_result.divide_fault)
        else $error("zero mass not flagged");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_item.mode, PIPE_LAT) == MODE_POS)
        |-> (o_result.new_velocity == $past(i_item.velocity, PIPE_LAT)
             && o_result.new_acceleration == $past(i_item.acceleration, PIPE_LAT)))
        else $error("position mode altered velocity fields");

endmodule

bind velocity_verlet_particle_update_top vv_chk u_vv_chk (.*);

`default_nettype wire
